[rtl/core/mtep_pkg.sv]
// Shared types and constants for the track event parser.
// Holds the event kind and error codes and the per-byte result record.
// No dependencies.
package mtep_pkg;

	localparam int COUNT_BITS_DEF = 24;

	localparam logic [7:0] STATUS_MIN   = 8'h80;
	localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
	localparam logic [7:0] META_STATUS  = 8'hFF;
	localparam logic [7:0] SYSEX_START  = 8'hF0;
	localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
	localparam logic [7:0] META_EOT     = 8'h2F;
	localparam logic [3:0] HI_PROGRAM   = 4'hC;
	localparam logic [3:0] HI_PRESSURE  = 4'hD;
	localparam logic [3:0] HI_SYSTEM    = 4'hF;
	localparam logic [2:0] VLQ_MAX_CONT = 3'd4;

	typedef enum logic [1:0] {
		KIND_TWO_DATA = 2'd0,
		KIND_ONE_DATA = 2'd1,
		KIND_META     = 2'd2,
		KIND_SYSEX    = 2'd3
	} mtep_kind_t;

	typedef enum logic [3:0] {
		ERR_NONE          = 4'd0,
		ERR_BAD_DELTA     = 4'd1,
		ERR_END_AFTER_DT  = 4'd2,
		ERR_NO_STATUS     = 4'd3,
		ERR_CUT_META      = 4'd4,
		ERR_BAD_META_LEN  = 4'd5,
		ERR_META_OVERRUN  = 4'd6,
		ERR_BAD_SYSEX_LEN = 4'd7,
		ERR_CUT_CHANNEL   = 4'd8
	} mtep_err_t;

	typedef struct packed {
		logic       event_done;
		mtep_kind_t event_kind;
		logic [7:0] status_value;
		logic [7:0] meta_kind;
		logic [31:0] event_tick;
		logic       data_warning;
		logic       unknown_stop;
		mtep_err_t  error_code;
		logic       track_done;
		logic       track_ok;
		logic       end_of_track_seen;
	} mtep_result_t;

endpackage

[rtl/core/midi_track_event_parser_core.sv]
// Track event parser top level: an accepted request is held in the stage 1 input register,
// and the parse step then loads its result into the result register (stage 2).
// Throughput is one byte per cycle unless out_ready low stalls the result register; the
// bound is the parse step, whose state registers feed the next byte's step directly.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser to the
// delta-time phase with all counters, flags and the error latch cleared.
// Depends on mtep_pkg and mtep_parser.
module midi_track_event_parser_core #(
	parameter int COUNT_BITS = mtep_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  event_done,
	output logic [1:0]            event_kind,
	output logic [7:0]            status_value,
	output logic [7:0]            meta_kind,
	output logic [31:0]           event_tick,
	output logic                  data_warning,
	output logic                  unknown_stop,
	output logic [3:0]            error_code,
	output logic                  track_done,
	output logic                  track_ok,
	output logic [COUNT_BITS-1:0] event_total,
	output logic                  end_of_track_seen
);

	// Stage 1 is a plain input register. Every byte produces exactly one result, so the
	// parse step runs whenever stage 1 holds a byte and the result register can take it.
	// The result register is stage 2; a new request is taken while a finished result
	// waits, as long as stage 1 can move on.
	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   last_s1;
	logic                   valid_s2;
	logic                   step;
	mtep_pkg::mtep_result_t res_s2;
	logic [COUNT_BITS-1:0]  total_s2;

	assign step     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (step) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	// The byte payload carries no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// The parser holds the track state and registers the result of each step.
	mtep_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res_s2    (res_s2),
		.total_s2  (total_s2)
	);

	assign out_valid         = valid_s2;
	assign event_done        = res_s2.event_done;
	assign event_kind        = res_s2.event_kind;
	assign status_value      = res_s2.status_value;
	assign meta_kind         = res_s2.meta_kind;
	assign event_tick        = res_s2.event_tick;
	assign data_warning      = res_s2.data_warning;
	assign unknown_stop      = res_s2.unknown_stop;
	assign error_code        = res_s2.error_code;
	assign track_done        = res_s2.track_done;
	assign track_ok          = res_s2.track_ok;
	assign event_total       = total_s2;
	assign end_of_track_seen = res_s2.end_of_track_seen;

	// A completed event never coincides with an error or a stop.
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_done) |-> (error_code == mtep_pkg::ERR_NONE && !unknown_stop))
		else $error("event completed alongside an error or stop");

	// A track can only be reported good on its final byte, with no error.
	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && track_ok) |-> (track_done && error_code == mtep_pkg::ERR_NONE))
		else $error("track_ok without track end or with an error");

	// A meta type only shows on a completed meta event.
	a_meta_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && meta_kind != 8'd0) |-> (event_done && event_kind == mtep_pkg::KIND_META))
		else $error("meta type shown on a non-meta result");

	// With the result register empty, the input side can never be stalled.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

endmodule

[rtl/core/mtep_parser.sv]
// Parse state machine for the track event parser: one byte per step.
// Holds all parse state and the registered result of the last step.
// Depends on mtep_pkg.
module mtep_parser #(
	parameter int COUNT_BITS = mtep_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              data_byte,
	input  logic                    last_byte,
	output mtep_pkg::mtep_result_t  res_s2,
	output logic [COUNT_BITS-1:0]   total_s2
);

	typedef enum logic [3:0] {
		PH_DELTA      = 4'd0,
		PH_STATUS     = 4'd1,
		PH_META_TYPE  = 4'd2,
		PH_META_LEN   = 4'd3,
		PH_META_SKIP  = 4'd4,
		PH_SYSEX_LEN  = 4'd5,
		PH_SYSEX_SKIP = 4'd6,
		PH_DATA1      = 4'd7,
		PH_DATA2      = 4'd8,
		PH_DATA_ONE   = 4'd9
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [7:0]            running_q, running_d;
	logic [7:0]            status_q, status_d;
	logic [7:0]            meta_q, meta_d;
	logic [31:0]           vlq_q, vlq_d;
	logic [2:0]            vcnt_q, vcnt_d;
	logic [31:0]           skip_q, skip_d;
	logic [31:0]           tick_q, tick_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic                  eot_q, eot_d;
	logic                  stop_q, stop_d;
	mtep_pkg::mtep_err_t   err_q, err_d;
	logic                  bad_q, bad_d;

	mtep_pkg::mtep_result_t res_d;
	mtep_pkg::mtep_kind_t   kind;
	mtep_pkg::mtep_err_t    err;
	logic                   done;
	logic                   warn;
	logic                   inc;
	logic [31:0]            feed_val;
	logic                   feed_more;
	logic                   feed_bad;
	logic [7:0]             st;
	logic                   running;
	logic [31:0]            skip_dec;

	always_comb begin
		phase_d   = phase_q;
		running_d = running_q;
		status_d  = status_q;
		meta_d    = meta_q;
		vlq_d     = vlq_q;
		vcnt_d    = vcnt_q;
		skip_d    = skip_q;
		tick_d    = tick_q;
		eot_d     = eot_q;
		stop_d    = stop_q;
		err_d     = err_q;
		bad_d     = bad_q;
		done      = 1'b0;
		kind      = mtep_pkg::KIND_TWO_DATA;
		warn      = 1'b0;
		err       = mtep_pkg::ERR_NONE;
		inc       = 1'b0;
		st        = data_byte;
		running   = 1'b0;
		skip_dec  = skip_q - 32'd1;

		// Variable-length quantity: seven bits per byte, top bit continues.
		feed_val  = {vlq_q[24:0], data_byte[6:0]};
		feed_more = data_byte[7];
		feed_bad  = data_byte[7] && (last_byte || (vcnt_q >= mtep_pkg::VLQ_MAX_CONT));

		if (err_q == mtep_pkg::ERR_NONE && !stop_q) begin
			case (phase_q)
				PH_STATUS: begin
					if (!data_byte[7] && running_q == 8'd0) begin
						err = mtep_pkg::ERR_NO_STATUS;
					end else begin
						running = !data_byte[7];
						st = running ? running_q : data_byte;
						if (data_byte[7] && data_byte < mtep_pkg::SYSTEM_MIN) begin
							running_d = data_byte;
						end
						status_d = st;
						meta_d   = 8'd0;
						bad_d    = 1'b0;
						if (st == mtep_pkg::META_STATUS) begin
							if (last_byte) err = mtep_pkg::ERR_CUT_META;
							else phase_d = PH_META_TYPE;
						end else if (st == mtep_pkg::SYSEX_START ||
								st == mtep_pkg::SYSEX_ESCAPE) begin
							if (last_byte) begin
								err = mtep_pkg::ERR_BAD_SYSEX_LEN;
							end else begin
								vlq_d   = 32'd0;
								vcnt_d  = 3'd0;
								phase_d = PH_SYSEX_LEN;
							end
						end else if (st[7:4] == mtep_pkg::HI_PROGRAM ||
								st[7:4] == mtep_pkg::HI_PRESSURE) begin
							// With running status this byte is already the data byte.
							if (running) begin
								done = 1'b1;
								kind = mtep_pkg::KIND_ONE_DATA;
							end else if (last_byte) begin
								err = mtep_pkg::ERR_CUT_CHANNEL;
							end else begin
								phase_d = PH_DATA_ONE;
							end
						end else if (st[7] && st[7:4] != mtep_pkg::HI_SYSTEM) begin
							if (last_byte) err = mtep_pkg::ERR_CUT_CHANNEL;
							else phase_d = running ? PH_DATA2 : PH_DATA1;
						end else begin
							stop_d = 1'b1;
						end
					end
				end
				PH_META_TYPE: begin
					meta_d = data_byte;
					if (last_byte) begin
						err = mtep_pkg::ERR_BAD_META_LEN;
					end else begin
						vlq_d   = 32'd0;
						vcnt_d  = 3'd0;
						phase_d = PH_META_LEN;
					end
				end
				PH_META_LEN: begin
					vlq_d = feed_val;
					if (feed_bad) begin
						err = mtep_pkg::ERR_BAD_META_LEN;
					end else if (feed_more) begin
						vcnt_d = vcnt_q + 3'd1;
					end else if (feed_val == 32'd0) begin
						done = 1'b1;
						kind = mtep_pkg::KIND_META;
					end else if (last_byte) begin
						err = mtep_pkg::ERR_META_OVERRUN;
					end else begin
						skip_d  = feed_val;
						phase_d = PH_META_SKIP;
					end
				end
				PH_META_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 32'd0) begin
						done = 1'b1;
						kind = mtep_pkg::KIND_META;
					end else if (last_byte) begin
						err = mtep_pkg::ERR_META_OVERRUN;
					end
				end
				PH_SYSEX_LEN: begin
					vlq_d = feed_val;
					if (feed_bad) begin
						err = mtep_pkg::ERR_BAD_SYSEX_LEN;
					end else if (feed_more) begin
						vcnt_d = vcnt_q + 3'd1;
					end else begin
						inc    = 1'b1;
						done   = 1'b1;
						kind   = mtep_pkg::KIND_SYSEX;
						skip_d = feed_val;
					end
				end
				PH_SYSEX_SKIP: begin
					if (skip_q != 32'd0) skip_d = skip_dec;
					if (skip_q == 32'd0 || skip_dec == 32'd0) begin
						vlq_d   = 32'd0;
						vcnt_d  = 3'd0;
						phase_d = PH_DELTA;
					end
				end
				PH_DATA1: begin
					if (data_byte[7]) bad_d = 1'b1;
					if (last_byte) err = mtep_pkg::ERR_CUT_CHANNEL;
					else phase_d = PH_DATA2;
				end
				PH_DATA2: begin
					if (data_byte[7]) bad_d = 1'b1;
					done = 1'b1;
					kind = mtep_pkg::KIND_TWO_DATA;
				end
				PH_DATA_ONE: begin
					if (data_byte[7]) bad_d = 1'b1;
					done = 1'b1;
					kind = mtep_pkg::KIND_ONE_DATA;
				end
				default: begin
					vlq_d = feed_val;
					if (feed_bad) begin
						err = mtep_pkg::ERR_BAD_DELTA;
					end else if (feed_more) begin
						vcnt_d  = vcnt_q + 3'd1;
						phase_d = PH_DELTA;
					end else begin
						tick_d = tick_q + feed_val;
						if (last_byte) err = mtep_pkg::ERR_END_AFTER_DT;
						else phase_d = PH_STATUS;
					end
				end
			endcase

			if (err != mtep_pkg::ERR_NONE) begin
				err_d = err;
				done  = 1'b0;
			end else if (done) begin
				if (kind == mtep_pkg::KIND_SYSEX) begin
					if (skip_d != 32'd0) begin
						phase_d = PH_SYSEX_SKIP;
					end else begin
						vlq_d   = 32'd0;
						vcnt_d  = 3'd0;
						phase_d = PH_DELTA;
					end
				end else begin
					inc = 1'b1;
					if (kind == mtep_pkg::KIND_META && meta_d == mtep_pkg::META_EOT) begin
						eot_d = 1'b1;
					end
					if (kind == mtep_pkg::KIND_TWO_DATA || kind == mtep_pkg::KIND_ONE_DATA) begin
						warn = bad_d;
					end
					vlq_d   = 32'd0;
					vcnt_d  = 3'd0;
					phase_d = PH_DELTA;
				end
			end
		end

		// The counter saturates at all ones.
		cnt_d = (inc && cnt_q != '1) ? cnt_q + COUNT_BITS'(1) : cnt_q;

		res_d.event_done        = done;
		res_d.event_kind        = done ? kind : mtep_pkg::KIND_TWO_DATA;
		res_d.status_value      = done ? status_d : 8'd0;
		res_d.meta_kind         = (done && kind == mtep_pkg::KIND_META) ? meta_d : 8'd0;
		res_d.event_tick        = done ? tick_d : 32'd0;
		res_d.data_warning      = done && warn;
		res_d.unknown_stop      = stop_d;
		res_d.error_code        = err_d;
		res_d.track_done        = last_byte;
		res_d.track_ok          = last_byte && (err_d == mtep_pkg::ERR_NONE);
		res_d.end_of_track_seen = eot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DELTA;
			running_q <= 8'd0;
			status_q  <= 8'd0;
			meta_q    <= 8'd0;
			vlq_q     <= 32'd0;
			vcnt_q    <= 3'd0;
			skip_q    <= 32'd0;
			tick_q    <= 32'd0;
			cnt_q     <= '0;
			eot_q     <= 1'b0;
			stop_q    <= 1'b0;
			err_q     <= mtep_pkg::ERR_NONE;
			bad_q     <= 1'b0;
			res_s2    <= '0;
			total_s2  <= '0;
		end else if (step) begin
			res_s2   <= res_d;
			total_s2 <= cnt_d;
			if (last_byte) begin
				// End of the track: all parse state returns to its reset value.
				phase_q   <= PH_DELTA;
				running_q <= 8'd0;
				status_q  <= 8'd0;
				meta_q    <= 8'd0;
				vlq_q     <= 32'd0;
				vcnt_q    <= 3'd0;
				skip_q    <= 32'd0;
				tick_q    <= 32'd0;
				cnt_q     <= '0;
				eot_q     <= 1'b0;
				stop_q    <= 1'b0;
				err_q     <= mtep_pkg::ERR_NONE;
				bad_q     <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				running_q <= running_d;
				status_q  <= status_d;
				meta_q    <= meta_d;
				vlq_q     <= vlq_d;
				vcnt_q    <= vcnt_d;
				skip_q    <= skip_d;
				tick_q    <= tick_d;
				cnt_q     <= cnt_d;
				eot_q     <= eot_d;
				stop_q    <= stop_d;
				err_q     <= err_d;
				bad_q     <= bad_d;
			end
		end
	end

endmodule
